// File: design/lpl_pkg.sv
// Package for the lookahead peak limiter.
// Holds register indexes, fixed field widths and the configuration types.
// No dependencies.
`timescale 1ns / 1ps

package lpl_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS_ON      = 3'd4;

    localparam int WL_W   = 14;
    localparam int REL_W  = 10;
    localparam int IG_W   = 21;
    localparam int OG_W   = 20;
    localparam int RED_W  = 17;
    localparam int FRAC_W = 16;

    localparam logic [WL_W-1:0]  WL_RESET  = 14'd64;
    localparam logic [REL_W-1:0] REL_RESET = 10'd76;
    localparam logic signed [IG_W-1:0] IG_RESET = 21'sd65536;
    localparam logic signed [OG_W-1:0] OG_RESET = 20'sd65536;

    localparam int MIN_WINDOW = 2;
    localparam logic [RED_W-1:0] RED_ONE = 17'd65536;
    localparam int RELEASE_SCALE = 500;

    typedef struct packed {
        logic [WL_W-1:0]        window_length;
        logic [REL_W-1:0]       release_factor;
        logic signed [IG_W-1:0] input_gain;
        logic signed [OG_W-1:0] output_gain;
        logic                   bypass_on;
    } cfg_t;

    typedef struct packed {
        cfg_t cfg;
        logic clear_req;
    } front_ctl_t;

endpackage

// File: design/lpl_fifo.sv
// Small first-in first-out queue between the front and back of the limiter.
// Depends on nothing.
`timescale 1ns / 1ps

module lpl_fifo #(
    parameter int WIDTH = 53,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (32'(wr_reg) == DEPTH - 1) ? '0 : PW'(wr_reg + 1'b1);
            end
            if (pop) begin
                rd_reg <= (32'(rd_reg) == DEPTH - 1) ? '0 : PW'(rd_reg + 1'b1);
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

endmodule

// File: design/lpl_front.sv
// Front of the limiter: configuration registers, input beat acceptance,
// input gain scaling and bypass marking. Depends on lpl_pkg.
`timescale 1ns / 1ps

module lpl_front import lpl_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic                          clearing,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [2*SAMPLE_BITS+4:0]      q_data,
    output front_ctl_t                    ctl
);

    localparam int S  = SAMPLE_BITS;
    localparam int DW = S + 4;

    cfg_t cfg_reg;
    logic st_valid_reg;
    logic st_byp_reg;
    logic signed [S-1:0] st_sample_reg;
    logic signed [S+IG_W-1:0] st_prod_reg;
    logic signed [S+4:0] shifted;
    logic signed [DW-1:0] scaled;
    logic accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign s_ready   = !clearing && (!st_valid_reg || !q_full);
    assign q_push    = st_valid_reg && !q_full;

    assign shifted = st_prod_reg[S+IG_W-1:FRAC_W];

    always_comb begin
        if (shifted[S+4] != shifted[S+3]) begin
            scaled = shifted[S+4] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            scaled = shifted[DW-1:0];
        end
    end

    assign q_data = {st_byp_reg, st_sample_reg, scaled};

    assign ctl.cfg       = cfg_reg;
    assign ctl.clear_req = cfg_valid && (cfg_index == REG_WINDOW_LENGTH)
                           && (cfg_data[WL_W-1:0] != cfg_reg.window_length);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_length  <= WL_RESET;
            cfg_reg.release_factor <= REL_RESET;
            cfg_reg.input_gain     <= IG_RESET;
            cfg_reg.output_gain    <= OG_RESET;
            cfg_reg.bypass_on      <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WINDOW_LENGTH:  cfg_reg.window_length  <= cfg_data[WL_W-1:0];
                REG_RELEASE_FACTOR: cfg_reg.release_factor <= cfg_data[REL_W-1:0];
                REG_INPUT_GAIN:     cfg_reg.input_gain     <= cfg_data[IG_W-1:0];
                REG_OUTPUT_GAIN:    cfg_reg.output_gain    <= cfg_data[OG_W-1:0];
                REG_BYPASS_ON:      cfg_reg.bypass_on      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (accept) begin
            st_valid_reg <= 1'b1;
        end else if (q_push) begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_byp_reg    <= cfg_reg.bypass_on;
            st_sample_reg <= s_sample_in;
            st_prod_reg   <= s_sample_in * cfg_reg.input_gain;
        end
    end

endmodule

// File: design/lpl_div.sv
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on nothing.
`timescale 1ns / 1ps

module lpl_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 28,
    parameter int Q_W   = 17
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quo
);

    localparam int CW = $clog2(Q_W + 1);

    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [Q_W-1:0] nsh_reg, quo_reg;
    logic [CW-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [DEN_W:0] trial;
    logic ge;

    assign trial = {rem_reg, nsh_reg[Q_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DEN_W'(num >> Q_W);
            nsh_reg <= num[Q_W-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            nsh_reg <= {nsh_reg[Q_W-2:0], 1'b0};
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

endmodule

// File: design/lpl_back.sv
// Back of the limiter: delay line, max tree, reduction, smoothing averages
// and output gain. Depends on lpl_pkg and lpl_div.
`timescale 1ns / 1ps

module lpl_back import lpl_pkg::*; #(
    parameter int MAX_WINDOW  = 8192,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  front_ctl_t                    ctl,
    output logic                          clearing,
    input  logic                          q_empty,
    input  logic [2*SAMPLE_BITS+4:0]      q_data,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic                          m_clipped
);

    localparam int S      = SAMPLE_BITS;
    localparam int DW     = S + 4;
    localparam int TL     = $clog2(MAX_WINDOW);
    localparam int HALF_MAX = MAX_WINDOW / 2;
    localparam int AP_W   = $clog2(HALF_MAX);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = AP_W + RED_W;
    localparam int NUM_W  = S + FRAC_W;
    localparam int P1_W   = DW + OG_W;
    localparam int T1_W   = P1_W - FRAC_W;
    localparam int P2_W   = T1_W + RED_W + 1;
    localparam int SH_W   = P2_W - FRAC_W;
    localparam int CMP_W  = RED_W + REL_W + 1;
    localparam logic [NUM_W-1:0] RECIP_NUM = {1'b1, {(NUM_W-1){1'b0}}};
    localparam logic [DW-1:0] UNITY = DW'(1) << (S - 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_BYP, ST_POP, ST_TREE, ST_PEAK, ST_RECIP,
        ST_AVG1, ST_WAIT1, ST_AVG2, ST_WAIT2, ST_REL, ST_MUL, ST_SAT
    } state_t;

    state_t state_reg;
    logic [TL:0] clr_cnt_reg;
    logic [TL-1:0] ptr_reg, ptr_use, ptr_nxt;
    logic [AP_W-1:0] ap_reg, ap_use, ap_nxt;
    logic [SUM_W-1:0] sum1_reg, sum2_reg, s1n, s2n;
    logic [LEN_W-1:0] len, half, ptr_inc, ap_inc;

    logic signed [S-1:0] sample_reg;
    logic signed [DW-1:0] scaled_reg, popped_reg;
    logic [DW-1:0] cur_reg, peak_reg, tree_max, pop_mag, scaled_mag;
    logic [TL:0] node_reg, par;
    logic [RED_W-1:0] red_reg, avg1_reg, avg2_reg;
    logic signed [P1_W-1:0] pmul_reg;
    logic signed [P2_W-1:0] t2_reg;
    logic signed [SH_W-1:0] t2_sh;
    logic signed [S-1:0] sat_val;
    logic ovf;
    logic [CMP_W-1:0] rel_lhs, rel_rhs;

    logic m_valid_reg, m_clip_reg;
    logic signed [S-1:0] m_sample_reg;
    logic out_free, launch, out_load;

    logic [DW-1:0] dly_mem [MAX_WINDOW];
    logic dly_we, dly_re;
    logic [TL-1:0] dly_wa;
    logic [DW-1:0] dly_wd, dly_rq_reg;

    logic [DW-1:0] tr_mem [2**(TL+1)];
    logic tr_we, tr_re;
    logic [TL:0] tr_wa, tr_ra;
    logic [DW-1:0] tr_wd, tr_rq_reg;

    logic [RED_W-1:0] a1_mem [HALF_MAX];
    logic [RED_W-1:0] a2_mem [HALF_MAX];
    logic a1_we, a2_we, a_re;
    logic [AP_W-1:0] a_wa;
    logic [RED_W-1:0] a1_wd, a2_wd, a1_rq_reg, a2_rq_reg;

    logic div_start, div_done;
    logic [NUM_W-1:0] div_num;
    logic [DW-1:0] div_den;
    logic [RED_W-1:0] div_q;

    lpl_div #(
        .NUM_W(NUM_W),
        .DEN_W(DW),
        .Q_W  (RED_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_q)
    );

    assign clearing = (state_reg == ST_CLEAR);
    assign out_free = !m_valid_reg || m_ready;
    assign launch   = (state_reg == ST_IDLE) && !q_empty && !ctl.clear_req;
    assign q_pop    = launch;
    assign out_load = !ctl.clear_req && out_free
                      && ((state_reg == ST_BYP) || (state_reg == ST_SAT));

    always_comb begin
        if (32'(ctl.cfg.window_length) < MIN_WINDOW) begin
            len = LEN_W'(MIN_WINDOW);
        end else if (32'(ctl.cfg.window_length) > MAX_WINDOW) begin
            len = LEN_W'(MAX_WINDOW);
        end else begin
            len = LEN_W'(ctl.cfg.window_length);
        end
    end
    assign half = len >> 1;

    assign ptr_use = (LEN_W'(ptr_reg) >= len) ? '0 : ptr_reg;
    assign ptr_inc = LEN_W'(ptr_use) + 1'b1;
    assign ptr_nxt = (ptr_inc >= len) ? '0 : ptr_inc[TL-1:0];
    assign ap_use  = (LEN_W'(ap_reg) >= half) ? '0 : ap_reg;
    assign ap_inc  = LEN_W'(ap_use) + 1'b1;
    assign ap_nxt  = (ap_inc >= half) ? '0 : ap_inc[AP_W-1:0];

    assign scaled_mag = scaled_reg[DW-1] ? DW'(~scaled_reg + 1'b1) : DW'(scaled_reg);
    assign pop_mag    = popped_reg[DW-1] ? DW'(~popped_reg + 1'b1) : DW'(popped_reg);
    assign par        = node_reg >> 1;
    assign tree_max   = (tr_rq_reg > cur_reg) ? tr_rq_reg : cur_reg;

    assign s1n = sum1_reg - SUM_W'(a1_rq_reg) + SUM_W'(red_reg);
    assign s2n = sum2_reg - SUM_W'(a2_rq_reg) + SUM_W'(avg1_reg);

    assign rel_lhs = CMP_W'(avg2_reg) * CMP_W'(RELEASE_SCALE);
    assign rel_rhs = CMP_W'(red_reg) * CMP_W'(ctl.cfg.release_factor);

    assign t2_sh = t2_reg[P2_W-1:FRAC_W];
    assign ovf   = !((&t2_sh[SH_W-1:S-1]) || !(|t2_sh[SH_W-1:S-1]));
    assign sat_val = ovf ? (t2_sh[SH_W-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}})
                         : t2_sh[S-1:0];

    always_comb begin
        dly_we = 1'b0;
        dly_wa = ptr_use;
        dly_wd = scaled_reg;
        dly_re = launch;
        tr_we  = 1'b0;
        tr_wa  = par;
        tr_wd  = tree_max;
        tr_re  = 1'b0;
        tr_ra  = par ^ (TL+1)'(1);
        a_re   = launch;
        a_wa   = ap_use;
        a1_we  = 1'b0;
        a2_we  = 1'b0;
        a1_wd  = red_reg;
        a2_wd  = div_q;
        div_start = 1'b0;
        div_num   = NUM_W'(s1n);
        div_den   = DW'(half);
        case (state_reg)
            ST_CLEAR: begin
                dly_we = (32'(clr_cnt_reg) < MAX_WINDOW);
                dly_wa = clr_cnt_reg[TL-1:0];
                dly_wd = '0;
                tr_we  = 1'b1;
                tr_wa  = clr_cnt_reg;
                tr_wd  = '0;
                a1_we  = (32'(clr_cnt_reg) < HALF_MAX);
                a2_we  = (32'(clr_cnt_reg) < HALF_MAX);
                a_wa   = clr_cnt_reg[AP_W-1:0];
                a1_wd  = '0;
                a2_wd  = '0;
            end
            ST_POP: begin
                dly_we = 1'b1;
                tr_we  = 1'b1;
                tr_wa  = {1'b1, ptr_use};
                tr_wd  = scaled_mag;
                tr_re  = 1'b1;
                tr_ra  = {1'b1, ptr_use} ^ (TL+1)'(1);
            end
            ST_TREE: begin
                tr_we = 1'b1;
                tr_re = 1'b1;
            end
            ST_PEAK: begin
                div_start = (peak_reg > UNITY);
                div_num   = RECIP_NUM;
                div_den   = peak_reg;
            end
            ST_AVG1: begin
                a1_we     = 1'b1;
                div_start = 1'b1;
            end
            ST_WAIT1: begin
                a2_we = 1'b0;
            end
            ST_AVG2: begin
                a2_we     = 1'b1;
                a2_wd     = avg1_reg;
                div_start = 1'b1;
                div_num   = NUM_W'(s2n);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (dly_we) begin
            dly_mem[dly_wa] <= dly_wd;
        end
        if (dly_re) begin
            dly_rq_reg <= dly_mem[ptr_use];
        end
    end

    always_ff @(posedge aclk) begin
        if (tr_we) begin
            tr_mem[tr_wa] <= tr_wd;
        end
        if (tr_re) begin
            tr_rq_reg <= tr_mem[tr_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (a1_we) begin
            a1_mem[a_wa] <= a1_wd;
        end
        if (a2_we) begin
            a2_mem[a_wa] <= a2_wd;
        end
        if (a_re) begin
            a1_rq_reg <= a1_mem[ap_use];
            a2_rq_reg <= a2_mem[ap_use];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            ptr_reg     <= '0;
            ap_reg      <= '0;
            sum1_reg    <= '0;
            sum2_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (ctl.clear_req) begin
                state_reg   <= ST_CLEAR;
                clr_cnt_reg <= '0;
                ptr_reg     <= '0;
                ap_reg      <= '0;
                sum1_reg    <= '0;
                sum2_reg    <= '0;
            end else begin
                case (state_reg)
                    ST_CLEAR: begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                        if (&clr_cnt_reg) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    ST_IDLE: begin
                        if (launch) begin
                            sample_reg <= q_data[2*S+3:DW];
                            scaled_reg <= q_data[DW-1:0];
                            state_reg  <= q_data[2*S+4] ? ST_BYP : ST_POP;
                        end
                    end
                    ST_BYP: begin
                        if (out_free) begin
                            m_sample_reg <= sample_reg;
                            m_clip_reg   <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end
                    end
                    ST_POP: begin
                        popped_reg <= dly_rq_reg;
                        cur_reg    <= scaled_mag;
                        node_reg   <= {1'b1, ptr_use};
                        ptr_reg    <= ptr_nxt;
                        state_reg  <= ST_TREE;
                    end
                    ST_TREE: begin
                        cur_reg  <= tree_max;
                        node_reg <= par;
                        if (par == (TL+1)'(1)) begin
                            peak_reg  <= (pop_mag > tree_max) ? pop_mag : tree_max;
                            state_reg <= ST_PEAK;
                        end
                    end
                    ST_PEAK: begin
                        if (peak_reg > UNITY) begin
                            state_reg <= ST_RECIP;
                        end else begin
                            red_reg   <= RED_ONE;
                            state_reg <= ST_AVG1;
                        end
                    end
                    ST_RECIP: begin
                        if (div_done) begin
                            red_reg   <= div_q;
                            state_reg <= ST_AVG1;
                        end
                    end
                    ST_AVG1: begin
                        sum1_reg  <= s1n;
                        state_reg <= ST_WAIT1;
                    end
                    ST_WAIT1: begin
                        if (div_done) begin
                            avg1_reg  <= div_q;
                            state_reg <= ST_AVG2;
                        end
                    end
                    ST_AVG2: begin
                        sum2_reg  <= s2n;
                        state_reg <= ST_WAIT2;
                    end
                    ST_WAIT2: begin
                        if (div_done) begin
                            avg2_reg  <= div_q;
                            ap_reg    <= ap_nxt;
                            state_reg <= ST_REL;
                        end
                    end
                    ST_REL: begin
                        if (rel_lhs > rel_rhs) begin
                            red_reg <= avg2_reg;
                        end
                        pmul_reg  <= popped_reg * ctl.cfg.output_gain;
                        state_reg <= ST_MUL;
                    end
                    ST_MUL: begin
                        t2_reg    <= $signed(pmul_reg[P1_W-1:FRAC_W])
                                     * $signed({1'b0, red_reg});
                        state_reg <= ST_SAT;
                    end
                    ST_SAT: begin
                        if (out_free) begin
                            m_sample_reg <= sat_val;
                            m_clip_reg   <= ovf;
                            state_reg    <= ST_IDLE;
                        end
                    end
                    default: begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_clipped    = m_clip_reg;

endmodule

// File: design/lookahead_peak_limiter.sv
// Lookahead peak limiter: one sample in, one limited sample out per beat.
// A limited sample walks up the window's max tree, one level per cycle, and
// then uses the shared one-bit-per-cycle divider, which forms the reduction
// (only when the peak exceeds unity) and both moving averages in turn. A
// bypassed sample skips both.
// After reset and after each change of window_length the block runs a
// clearing pass over its memories during which it takes no sample;
// configuration writes are always taken.
// A two-entry queue lets a new sample enter while a result waits.
`timescale 1ns / 1ps

module lookahead_peak_limiter import lpl_pkg::*; #(
    parameter int MAX_WINDOW  = 8192,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic                          m_clipped
);

    localparam int ITEM_W = 2 * SAMPLE_BITS + 5;

    front_ctl_t ctl;
    logic clearing, q_full, q_empty, q_push, q_pop;
    logic [ITEM_W-1:0] q_in, q_out;

    lpl_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample_in(s_sample_in),
        .clearing   (clearing),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in),
        .ctl        (ctl)
    );

    lpl_fifo #(
        .WIDTH(ITEM_W),
        .DEPTH(2)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_in),
        .pop      (q_pop),
        .pop_data (q_out),
        .full     (q_full),
        .empty    (q_empty)
    );

    lpl_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .clearing    (clearing),
        .q_empty     (q_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample_out(m_sample_out),
        .m_clipped   (m_clipped)
    );

endmodule

// File: tb/lpl_checker.sv
// Checker for the lookahead peak limiter: watches the configuration, sample and
// result channels, predicts each limited sample and compares it on arrival.
// Depends on lpl_pkg for register indexes and field widths.
`timescale 1ns / 1ps

module lpl_checker import lpl_pkg::*; #(
    parameter int MAX_WINDOW  = 8192,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [SAMPLE_BITS-1:0] m_sample_out,
    input  logic                          m_clipped,
    output int                            error_count,
    output int                            pending_count
);

    localparam int DELAY_W = SAMPLE_BITS + 4;
    localparam int HALF_MAX = MAX_WINDOW / 2;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clipped;
    } limited_t;

    limited_t expected_samples[$];

    longint delay_line[MAX_WINDOW];
    longint first_avg_line[HALF_MAX];
    longint second_avg_line[HALF_MAX];
    int     delay_pos;
    int     avg_pos;
    longint first_sum;
    longint second_sum;
    cfg_t   cfg_now;

    function automatic longint saturate(longint x, int bits, ref logic hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (x < lo) begin
            hit = 1'b1;
            return lo;
        end
        return x;
    endfunction

    function automatic longint magnitude(longint x);
        return (x < 0) ? -x : x;
    endfunction

    task automatic clear_lines();
        for (int i = 0; i < MAX_WINDOW; i++) delay_line[i] = 0;
        for (int i = 0; i < HALF_MAX; i++) begin
            first_avg_line[i] = 0;
            second_avg_line[i] = 0;
        end
        delay_pos = 0;
        avg_pos = 0;
        first_sum = 0;
        second_sum = 0;
    endtask

    task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WINDOW_LENGTH: begin
                if (data[WL_W-1:0] != cfg_now.window_length) clear_lines();
                cfg_now.window_length = data[WL_W-1:0];
            end
            REG_RELEASE_FACTOR: cfg_now.release_factor = data[REL_W-1:0];
            REG_INPUT_GAIN:     cfg_now.input_gain = data[IG_W-1:0];
            REG_OUTPUT_GAIN:    cfg_now.output_gain = data[OG_W-1:0];
            REG_BYPASS_ON:      cfg_now.bypass_on = data[0];
            default: ;
        endcase
    endtask

    function automatic limited_t limit_sample(logic signed [SAMPLE_BITS-1:0] din);
        limited_t res;
        int       len;
        int       half;
        longint   scaled;
        longint   popped;
        longint   peak;
        longint   red;
        longint   avg1;
        longint   avg2;
        longint   t;
        logic     hit;
        hit = 1'b0;
        if (cfg_now.bypass_on) begin
            res.sample = din;
            res.clipped = 1'b0;
            return res;
        end
        len = cfg_now.window_length;
        if (len < MIN_WINDOW) len = MIN_WINDOW;
        if (len > MAX_WINDOW) len = MAX_WINDOW;
        half = len / 2;

        scaled = (longint'(din) * longint'(cfg_now.input_gain)) >>> FRAC_W;
        scaled = saturate(scaled, DELAY_W, hit);
        hit = 1'b0;

        if (delay_pos >= len) delay_pos = 0;
        popped = delay_line[delay_pos];
        delay_line[delay_pos] = scaled;
        delay_pos = (delay_pos + 1 >= len) ? 0 : delay_pos + 1;

        peak = 0;
        for (int i = 0; i < len; i++) begin
            if (magnitude(delay_line[i]) > peak) peak = magnitude(delay_line[i]);
        end
        if (magnitude(popped) > peak) peak = magnitude(popped);

        if (peak > (longint'(1) <<< (SAMPLE_BITS - 1)))
            red = (longint'(RED_ONE) <<< (SAMPLE_BITS - 1)) / peak;
        else
            red = RED_ONE;

        if (avg_pos >= half) avg_pos = 0;
        first_sum = first_sum - first_avg_line[avg_pos] + red;
        first_avg_line[avg_pos] = red;
        avg1 = first_sum / half;
        second_sum = second_sum - second_avg_line[avg_pos] + avg1;
        second_avg_line[avg_pos] = avg1;
        avg2 = second_sum / half;
        avg_pos = (avg_pos + 1 >= half) ? 0 : avg_pos + 1;

        if (avg2 * RELEASE_SCALE > red * longint'(cfg_now.release_factor)) red = avg2;

        t = (popped * longint'(cfg_now.output_gain)) >>> FRAC_W;
        t = (t * red) >>> FRAC_W;
        t = saturate(t, SAMPLE_BITS, hit);
        res.sample = t[SAMPLE_BITS-1:0];
        res.clipped = hit;
        return res;
    endfunction

    assign pending_count = expected_samples.size();

    always @(posedge aclk) begin
        limited_t want;
        if (!aresetn) begin
            clear_lines();
            cfg_now.window_length = WL_RESET;
            cfg_now.release_factor = REL_RESET;
            cfg_now.input_gain = IG_RESET;
            cfg_now.output_gain = OG_RESET;
            cfg_now.bypass_on = 1'b0;
            expected_samples.delete();
            error_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
            if (s_valid && s_ready) expected_samples.push_back(limit_sample(s_sample_in));
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected result beat sample=%0d clipped=%0b",
                             $time, m_sample_out, m_clipped);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_samples.pop_front();
                    if (want.sample !== m_sample_out || want.clipped !== m_clipped) begin
                        $display("%0t: mismatch expected sample=%0d clipped=%0b, actual sample=%0d clipped=%0b",
                                 $time, want.sample, want.clipped, m_sample_out, m_clipped);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: tb/lookahead_peak_limiter_tb.sv
// Testbench top for the lookahead peak limiter: drives configuration phases and
// samples with random gaps and stalls, and reports the verdict of lpl_checker.
// Depends on lpl_pkg, lookahead_peak_limiter and lpl_checker.
`timescale 1ns / 1ps

module lookahead_peak_limiter_tb;
    import lpl_pkg::*;

    localparam int SAMPLE_BITS = 24;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample_in;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [SAMPLE_BITS-1:0] m_sample_out;
    logic                          m_clipped;
    int                            error_count;
    int                            pending_count;
    bit                            long_hold_req;

    lookahead_peak_limiter dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample_in(s_sample_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sample_out(m_sample_out), .m_clipped(m_clipped)
    );

    lpl_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample_in(s_sample_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sample_out(m_sample_out), .m_clipped(m_clipped),
        .error_count(error_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return SAMPLE_BITS'($urandom);
            1: return $urandom_range(0, 1)
                      ? SAMPLE_BITS'(24'h7FFFFF - $urandom_range(0, 4095))
                      : SAMPLE_BITS'(24'h800000 + $urandom_range(0, 4095));
            2: return {{12{$urandom_range(0, 1) == 1}}, 12'($urandom)};
            default: return {{4{$urandom_range(0, 1) == 1}}, 20'($urandom)};
        endcase
    endfunction

    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(logic [SAMPLE_BITS-1:0] value, bit no_gap);
        int gap;
        s_valid     <= 1'b1;
        s_sample_in <= value;
        do @(posedge aclk); while (!s_ready);
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic set_all(int wl, int rel, int ig, int og, bit byp);
        write_reg(REG_WINDOW_LENGTH, wl);
        write_reg(REG_RELEASE_FACTOR, rel);
        write_reg(REG_INPUT_GAIN, ig);
        write_reg(REG_OUTPUT_GAIN, og);
        write_reg(REG_BYPASS_ON, CFG_DATA_W'(byp));
    endtask

    task automatic run_random(int count, bit steady);
        for (int i = 0; i < count; i++) send_sample(pick_sample(), steady);
    endtask

    initial begin
        logic [SAMPLE_BITS-1:0] directed[$];
        int wl;
        aresetn       = 1'b0;
        long_hold_req = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_sample_in   = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        directed = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001,
                     24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h400000, 24'hC00000,
                     24'h000000, 24'h000000, 24'h555555, 24'hAAAAAA, 24'h7FFFFF,
                     24'h800001, 24'h000010, 24'hFFFFF0};
        foreach (directed[i]) send_sample(directed[i], 1'b0);
        drain();

        set_all(2, 0, 983040, -327680, 1'b0);
        run_random(120, 1'b0);
        drain();

        set_all(1, 1023, -1048576, 524287, 1'b0);
        run_random(60, 1'b0);
        drain();

        set_all(16383, 1000, 1048575, -524288, 1'b0);
        run_random(12, 1'b0);
        drain();

        set_all(0, 500, 327680, 65536, 1'b1);
        run_random(60, 1'b0);
        drain();

        set_all(32, 76, 131072, 98304, 1'b0);
        long_hold_req = 1'b1;
        run_random(120, 1'b1);
        drain();

        for (int p = 0; p < 14; p++) begin
            wl = ($urandom_range(0, 9) == 0) ? $urandom_range(129, 1024)
                                             : $urandom_range(2, 128);
            set_all(wl, $urandom_range(0, 1023), $urandom_range(0, 2097151),
                    $urandom_range(0, 1048575), $urandom_range(0, 9) == 0);
            run_random(95, $urandom_range(0, 4) == 0);
            drain();
        end

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
design/lpl_pkg.sv
design/lpl_fifo.sv
design/lpl_front.sv
design/lpl_div.sv
design/lpl_back.sv
design/lookahead_peak_limiter.sv
tb/lpl_checker.sv
tb/lookahead_peak_limiter_tb.sv
